### rtl/jdc_pkg.sv
package jdc_pkg;

    localparam int unsigned JdnW   = 31;
    localparam int unsigned WordW  = 32;
    localparam int unsigned YearW  = 24;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned DayIdxW = 9;

    localparam logic [WordW-1:0] JdnOffset   = 32'd32044;
    localparam logic [WordW-1:0] OriginShift = 32'd60;

    localparam logic [17:0] Cycle400Days = 18'd146097;
    localparam logic [10:0] Cycle4Days   = 11'd1461;

    localparam logic [WordW-1:0] Recip400  = 32'((64'd1 << 49) / 64'd146097);
    localparam int unsigned      Recip400Sh = 49;
    localparam logic [WordW-1:0] Recip1461 = 32'((64'd1 << 42) / 64'd1461);
    localparam int unsigned      Recip1461Sh = 42;

    localparam logic [11:0] MonthMul   = 12'd2141;
    localparam logic [12:0] MonthDays  = 13'd7834;

    localparam logic [YearW-1:0] YearBase = 24'd4800;

    localparam logic signed [YearW-1:0] LowYear   = -24'sd4713;
    localparam logic [MonthW-1:0]       LowMonth  = 4'd11;
    localparam logic signed [YearW-1:0] HighYear  = 24'sd5874898;
    localparam logic [MonthW-1:0]       HighMonth = 4'd6;

    typedef struct packed {
        logic [WordW-1:0] t2;
    } t_cyc_data;

    typedef struct packed {
        logic signed [YearW-1:0] year;
        logic [DayIdxW-1:0]      day_idx;
    } t_yr_data;

    typedef struct packed {
        logic signed [YearW-1:0] year;
        logic [MonthW-1:0]       month;
        logic [DayW-1:0]         day_of_month;
        logic                    in_range;
    } t_date;

endpackage

### rtl/jdc_if.sv
interface jdc_in_if
    import jdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [JdnW-1:0]    julian_day;

    modport source (output valid, output julian_day, input ready);
    modport sink   (input valid, input julian_day, output ready);
endinterface

interface jdc_out_if
    import jdc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [YearW-1:0] year;
    logic [MonthW-1:0]       month;
    logic [DayW-1:0]         day_of_month;
    logic                    in_range;

    modport source (output valid, output year, output month, output day_of_month,
                    output in_range, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input in_range, output ready);
endinterface

### rtl/julian_day_to_calendar_date_core.sv
// Julian day number to proleptic Gregorian date converter.
//
// Input channel i_in carries one Julian day number per item; output channel
// o_out carries year (two's complement, 0 is 1 BC), month, day of month and
// an in_range flag for dates from -4713-11 up to but not including 5874898-06.
// Both channels use valid/ready; an item moves on a clock edge with both high.
//
// An item accepted on i_in passes through the eleven register stages
// (400-year split, 4-year split, month split) before o_out.valid rises.
// Throughput: one item per cycle, sustained, with no gaps between items,
// while the receiver keeps o_out.ready high.
//
// Each stage carries its own valid bit and advances when its successor is
// empty or moving, so a stalled receiver holds the output item and fills the
// empty stages behind it before i_in.ready drops; nothing is lost or repeated.
//
// Synchronous reset empties every stage; the block holds no other state and
// needs no setup after reset.
module julian_day_to_calendar_date_core
    import jdc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    jdc_in_if.sink         i_in,
    jdc_out_if.source      o_out
);
    logic      cyc_valid;
    logic      cyc_ready;
    t_cyc_data cyc_data;
    logic      yr_valid;
    logic      yr_ready;
    t_yr_data  yr_data;
    t_date     date;

    jdc_cycle_div u_cycle_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_jdn   (i_in.julian_day),
        .o_valid (cyc_valid),
        .i_ready (cyc_ready),
        .o_data  (cyc_data)
    );

    jdc_year_div u_year_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cyc_valid),
        .o_ready (cyc_ready),
        .i_data  (cyc_data),
        .o_valid (yr_valid),
        .i_ready (yr_ready),
        .o_data  (yr_data)
    );

    jdc_month_split u_month_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yr_valid),
        .o_ready (yr_ready),
        .i_data  (yr_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_date  (date)
    );

    assign o_out.year         = date.year;
    assign o_out.month        = date.month;
    assign o_out.day_of_month = date.day_of_month;
    assign o_out.in_range     = date.in_range;

endmodule

### rtl/jdc_cycle_div.sv
module jdc_cycle_div
    import jdc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [JdnW-1:0] i_jdn,
    output logic            o_valid,
    input  logic            i_ready,
    output t_cyc_data       o_data
);
    localparam int unsigned Stages = 5;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] en;

    logic [WordW-1:0] r1_t;
    logic [WordW-1:0] r2_t;
    logic [14:0]      r2_q0;
    logic [WordW-1:0] r3_t;
    logic [14:0]      r3_q0;
    logic [18:0]      r3_r0;
    logic [WordW-1:0] r4_t;
    logic [14:0]      r4_q;
    logic [17:0]      r4_r;
    logic [WordW-1:0] r5_t2;

    logic [WordW-1:0]   n1_t;
    logic [2*WordW-1:0] n2_prod;
    logic [WordW-1:0]   n3_prod;
    logic [WordW-1:0]   n3_diff;
    logic [14:0]        n4_q;
    logic [17:0]        n4_r;
    logic [19:0]        n5_rem4;
    logic [1:0]         n5_q4;
    logic [WordW-1:0]   n5_t2;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || i_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_comb begin
        n1_t    = {1'b0, i_jdn} + JdnOffset;
        n2_prod = {32'd0, r1_t} * {32'd0, Recip400};
        n3_prod = {17'd0, r2_q0} * {14'd0, Cycle400Days};
        n3_diff = r2_t - n3_prod;
        if (r3_r0 >= {1'b0, Cycle400Days}) begin
            n4_q = r3_q0 + 15'd1;
            n4_r = 18'(r3_r0 - {1'b0, Cycle400Days});
        end else begin
            n4_q = r3_q0;
            n4_r = r3_r0[17:0];
        end
        n5_rem4 = {r4_r, 2'b11};
        if (n5_rem4 >= 20'(3 * 146097)) begin
            n5_q4 = 2'd3;
        end else if (n5_rem4 >= 20'(2 * 146097)) begin
            n5_q4 = 2'd2;
        end else if (n5_rem4 >= {2'b00, Cycle400Days}) begin
            n5_q4 = 2'd1;
        end else begin
            n5_q4 = 2'd0;
        end
        n5_t2 = r4_t + OriginShift + {16'd0, r4_q, 1'b0} + {17'd0, r4_q} + {30'd0, n5_q4};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_t <= n1_t;
        end
        if (en[1]) begin
            r2_t  <= r1_t;
            r2_q0 <= n2_prod[Recip400Sh+14:Recip400Sh];
        end
        if (en[2]) begin
            r3_t  <= r2_t;
            r3_q0 <= r2_q0;
            r3_r0 <= n3_diff[18:0];
        end
        if (en[3]) begin
            r4_t <= r3_t;
            r4_q <= n4_q;
            r4_r <= n4_r;
        end
        if (en[4]) begin
            r5_t2 <= n5_t2;
        end
    end

    assign o_ready   = en[0];
    assign o_valid   = r_vld[Stages-1];
    assign o_data.t2 = r5_t2;

endmodule

### rtl/jdc_year_div.sv
module jdc_year_div
    import jdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cyc_data i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_yr_data  o_data
);
    localparam int unsigned Stages = 4;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] en;

    logic [WordW-1:0]   r1_t;
    logic [21:0]        r1_q0;
    logic [21:0]        r2_q0;
    logic [11:0]        r2_r0;
    logic [21:0]        r3_c4;
    logic [10:0]        r3_t3;
    logic signed [YearW-1:0] r4_year;
    logic [DayIdxW-1:0] r4_day_idx;

    logic [2*WordW-1:0] n1_prod;
    logic [WordW-1:0]   n2_prod;
    logic [WordW-1:0]   n2_diff;
    logic [21:0]        n3_c4;
    logic [10:0]        n3_t3;
    logic [12:0]        n4_quarter;
    logic [1:0]         n4_y;
    logic [10:0]        n4_v365;
    logic [10:0]        n4_v366;
    logic [10:0]        n4_t4;
    logic [10:0]        n4_t5;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || i_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_comb begin
        n1_prod = {32'd0, i_data.t2} * {32'd0, Recip1461};
        n2_prod = {10'd0, r1_q0} * {21'd0, Cycle4Days};
        n2_diff = r1_t - n2_prod;
        if (r2_r0 >= {1'b0, Cycle4Days}) begin
            n3_c4 = r2_q0 + 22'd1;
            n3_t3 = 11'(r2_r0 - {1'b0, Cycle4Days});
        end else begin
            n3_c4 = r2_q0;
            n3_t3 = r2_r0[10:0];
        end

        n4_quarter = {r3_t3, 2'b00};
        if (n4_quarter >= 13'd4383) begin
            n4_y = 2'd3;
        end else if (n4_quarter >= 13'd2922) begin
            n4_y = 2'd2;
        end else if (n4_quarter >= {2'b00, Cycle4Days}) begin
            n4_y = 2'd1;
        end else begin
            n4_y = 2'd0;
        end

        n4_v365 = r3_t3 + 11'd305;
        n4_v366 = r3_t3 + 11'd306;
        if (n4_y != 2'd0) begin
            if (n4_v365 >= 11'd1460) begin
                n4_t4 = n4_v365 - 11'd1460;
            end else if (n4_v365 >= 11'd1095) begin
                n4_t4 = n4_v365 - 11'd1095;
            end else if (n4_v365 >= 11'd730) begin
                n4_t4 = n4_v365 - 11'd730;
            end else if (n4_v365 >= 11'd365) begin
                n4_t4 = n4_v365 - 11'd365;
            end else begin
                n4_t4 = n4_v365;
            end
        end else begin
            if (n4_v366 >= 11'd366) begin
                n4_t4 = n4_v366 - 11'd366;
            end else begin
                n4_t4 = n4_v366;
            end
        end
        n4_t5 = n4_t4 + 11'd123;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_t  <= i_data.t2;
            r1_q0 <= n1_prod[Recip1461Sh+21:Recip1461Sh];
        end
        if (en[1]) begin
            r2_q0 <= r1_q0;
            r2_r0 <= n2_diff[11:0];
        end
        if (en[2]) begin
            r3_c4 <= n3_c4;
            r3_t3 <= n3_t3;
        end
        if (en[3]) begin
            r4_year    <= $signed({r3_c4, n4_y} - YearBase);
            r4_day_idx <= n4_t5[DayIdxW-1:0];
        end
    end

    assign o_ready        = en[0];
    assign o_valid        = r_vld[Stages-1];
    assign o_data.year    = r4_year;
    assign o_data.day_idx = r4_day_idx;

endmodule

### rtl/jdc_month_split.sv
module jdc_month_split
    import jdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_yr_data i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_date    o_date
);
    localparam int unsigned Stages = 2;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] en;

    logic signed [YearW-1:0] r1_year;
    logic [DayIdxW-1:0]      r1_t5;
    logic [MonthW-1:0]       r1_mq;
    t_date                   r2_date;

    logic [20:0]        n1_prod;
    logic [16:0]        n2_prod;
    logic [DayIdxW-1:0] n2_day;
    logic [4:0]         n2_shift;
    logic [4:0]         n2_mod;
    logic [MonthW-1:0]  n2_month;
    logic               n2_above;
    logic               n2_below;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || i_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_comb begin
        n1_prod  = {12'd0, i_data.day_idx} * {9'd0, MonthMul};
        n2_prod  = {13'd0, r1_mq} * {4'd0, MonthDays};
        n2_day   = r1_t5 - n2_prod[16:8];
        n2_shift = {1'b0, r1_mq} + 5'd10;
        if (n2_shift >= 5'd24) begin
            n2_mod = n2_shift - 5'd24;
        end else if (n2_shift >= 5'd12) begin
            n2_mod = n2_shift - 5'd12;
        end else begin
            n2_mod = n2_shift;
        end
        n2_month = n2_mod[MonthW-1:0] + 4'd1;
        n2_above = (r1_year > LowYear) || ((r1_year == LowYear) && (n2_month >= LowMonth));
        n2_below = (r1_year < HighYear) || ((r1_year == HighYear) && (n2_month < HighMonth));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_year <= i_data.year;
            r1_t5   <= i_data.day_idx;
            r1_mq   <= n1_prod[19:16];
        end
        if (en[1]) begin
            r2_date.year         <= r1_year;
            r2_date.month        <= n2_month;
            r2_date.day_of_month <= n2_day[DayW-1:0];
            r2_date.in_range     <= n2_above && n2_below;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[Stages-1];
    assign o_date  = r2_date;

endmodule

### rtl/jdc_checker.sv
module jdc_checker
    import jdc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [YearW-1:0] i_year,
    input  logic [MonthW-1:0]       i_month,
    input  logic [DayW-1:0]         i_day_of_month,
    input  logic                    i_in_range
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_month_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_month >= 4'd1) && (i_month <= 4'd12))
        else $error("month out of 1..12");

    a_day_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_day_of_month != 5'd0))
        else $error("day of month is zero");

    a_range_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_range |-> (i_year >= LowYear) && (i_year <= HighYear))
        else $error("in_range set for year outside supported span");

endmodule

bind julian_day_to_calendar_date_core jdc_checker u_jdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_year         (o_out.year),
    .i_month        (o_out.month),
    .i_day_of_month (o_out.day_of_month),
    .i_in_range     (o_out.in_range)
);

### verif/tb_julian_day_to_calendar_date_core.sv
module tb_julian_day_to_calendar_date_core
    import jdc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [JdnW-1:0] jdn;
        t_date           date;
    } t_conversion;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jdc_in_if  day_ch ();
    jdc_out_if date_ch ();

    julian_day_to_calendar_date_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (day_ch),
        .o_out   (date_ch)
    );

    always #5 i_clk = ~i_clk;

    t_conversion pending_dates[$];
    int          fail_count    = 0;
    int          tx_wait_max   = 0;
    int          rx_wait_max   = 0;
    int          rx_hold_cycles = 0;

    function automatic t_date civil_date_of(input logic [JdnW-1:0] jdn);
        logic [31:0] t;
        logic [31:0] cycles400;
        logic [31:0] rem4;
        logic [31:0] cycles4;
        logic [31:0] yr_in_cycle;
        logic [31:0] years_total;
        logic [31:0] month_idx;
        logic [31:0] mon;
        logic [31:0] dom;
        int          yr;
        t_date       d;
        t = 32'(jdn) + 32'd32044;
        cycles400 = t / 32'd146097;
        rem4 = (t - cycles400 * 32'd146097) * 32'd4 + 32'd3;
        t = t + 32'd60 + cycles400 * 32'd3 + rem4 / 32'd146097;
        cycles4 = t / 32'd1461;
        t = t - cycles4 * 32'd1461;
        yr_in_cycle = t * 32'd4 / 32'd1461;
        if (yr_in_cycle != 32'd0) begin
            t = (t + 32'd305) % 32'd365;
        end else begin
            t = (t + 32'd306) % 32'd366;
        end
        t = t + 32'd123;
        years_total = yr_in_cycle + cycles4 * 32'd4;
        yr = int'(years_total) - 4800;
        month_idx = t * 32'd2141 / 32'd65536;
        dom = t - 32'd7834 * month_idx / 32'd256;
        mon = (month_idx + 32'd10) % 32'd12 + 32'd1;
        d.year         = yr[YearW-1:0];
        d.month        = mon[MonthW-1:0];
        d.day_of_month = dom[DayW-1:0];
        d.in_range     = (yr > -4713 || (yr == -4713 && mon >= 32'd11)) &&
                         (yr < 5874898 || (yr == 5874898 && mon < 32'd6));
        return d;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_conversion want;
        t_date       got;
        if (i_rst_n && date_ch.valid && date_ch.ready) begin
            got.year         = date_ch.year;
            got.month        = date_ch.month;
            got.day_of_month = date_ch.day_of_month;
            got.in_range     = date_ch.in_range;
            if (pending_dates.size() == 0) begin
                note_failure($sformatf("unexpected date %0d-%0d-%0d in_range=%0b",
                    got.year, got.month, got.day_of_month, got.in_range));
            end else begin
                want = pending_dates.pop_front();
                if (got.year !== want.date.year || got.month !== want.date.month ||
                    got.day_of_month !== want.date.day_of_month ||
                    got.in_range !== want.date.in_range) begin
                    note_failure($sformatf(
                        "day %0d: expected %0d-%0d-%0d r%0b, got %0d-%0d-%0d r%0b",
                        want.jdn, want.date.year, want.date.month,
                        want.date.day_of_month, want.date.in_range,
                        got.year, got.month, got.day_of_month, got.in_range));
                end
            end
        end
    end

    // Receiver: per-item wait, plus an occasional long hold-off.
    initial begin
        int w;
        date_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                w = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                w = $urandom_range(0, rx_wait_max);
            end
            if (w > 0) begin
                date_ch.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            date_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(date_ch.valid && date_ch.ready));
            @(negedge i_clk);
        end
    end

    task automatic send_day(input logic [JdnW-1:0] jdn);
        int gap;
        t_conversion c;
        gap = $urandom_range(0, tx_wait_max);
        if (gap > 0) begin
            day_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        day_ch.valid      <= 1'b1;
        day_ch.julian_day <= jdn;
        do @(posedge i_clk); while (!day_ch.ready);
        c.jdn  = jdn;
        c.date = civil_date_of(jdn);
        pending_dates.push_back(c);
        @(negedge i_clk);
    endtask

    task automatic wait_all_dates;
        day_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_dates.size() > 0);
    endtask

    function automatic logic [JdnW-1:0] random_day();
        longint k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return JdnW'($urandom());
            4, 5, 6:    return JdnW'($urandom_range(0, 3000000));
            7:          return JdnW'(2147483647 - $urandom_range(0, 3000));
            8:          return JdnW'($urandom_range(0, 400));
            default: begin
                k = $urandom_range(1, 14698);
                return JdnW'(k * 146097 - 32044 + $urandom_range(0, 4) - 2);
            end
        endcase
    endfunction

    task automatic test_edge_dates;
        logic [JdnW-1:0] days[$];
        days = '{31'd0, 31'd1, 31'd2147483647, 31'd2147483646, 31'd2147483645,
                 31'd2147483644, 31'd2147483643, 31'd1721059, 31'd1721060,
                 31'd1721425, 31'd1721426, 31'd2451544, 31'd2451545,
                 31'd2451604, 31'd2451605, 31'd2415079, 31'd2415080,
                 31'd2299160, 31'd2299161, 31'd114052, 31'd114053,
                 31'd1073741824, 31'd1431655765, 31'd715827882};
        tx_wait_max = 3;
        rx_wait_max = 3;
        foreach (days[i]) send_day(days[i]);
    endtask

    task automatic test_random_dates;
        tx_wait_max = 16;
        rx_wait_max = 16;
        repeat (200) send_day(random_day());
    endtask

    task automatic test_streaming;
        tx_wait_max = 0;
        rx_wait_max = 0;
        repeat (150) send_day(random_day());
    endtask

    task automatic test_output_stall;
        tx_wait_max = 0;
        rx_wait_max = 2;
        rx_hold_cycles = 80;
        repeat (40) send_day(random_day());
        wait_all_dates();
    endtask

    task automatic test_mixed_rates;
        for (int i = 0; i < 160; i++) begin
            if (i % 20 == 0) begin
                tx_wait_max = ($urandom_range(0, 1) != 0) ? 16 : 0;
                rx_wait_max = ($urandom_range(0, 1) != 0) ? 16 : 0;
            end
            send_day(random_day());
        end
    endtask

    initial begin
        day_ch.valid      = 1'b0;
        day_ch.julian_day = '0;
        i_rst_n           = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_dates();
        test_random_dates();
        test_streaming();
        test_output_stall();
        test_mixed_rates();

        wait_all_dates();
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && pending_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
